[rtl/scp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the sensor command line parser.
// ---------------------------------------------------------------------------
package scp_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    typedef logic [0:0]            cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_index_t REG_START_PERIOD  = 1'd0;
    localparam cfg_index_t REG_START_CELSIUS = 1'd1;

    // Fault codes
    typedef logic [1:0] fault_t;
    localparam fault_t FAULT_NONE     = 2'd0;
    localparam fault_t FAULT_INVALID  = 2'd1;
    localparam fault_t FAULT_PERIOD   = 2'd2;
    localparam fault_t FAULT_TOO_LONG = 2'd3;

    // Keyword indices, in match priority order
    localparam int KW_COUNT = 6;
    typedef logic [2:0] kw_idx_t;
    localparam kw_idx_t KW_OFF     = 3'd0;
    localparam kw_idx_t KW_STOP    = 3'd1;
    localparam kw_idx_t KW_START   = 3'd2;
    localparam kw_idx_t KW_SCALE_F = 3'd3;
    localparam kw_idx_t KW_SCALE_C = 3'd4;
    localparam kw_idx_t KW_PERIOD  = 3'd5;

    // Digits of the period start after "PERIOD="
    localparam int DIGIT_START = 7;

    // Keyword text, left aligned in seven characters
    localparam logic [55:0] TXT_OFF     = {"OFF", 32'h0};
    localparam logic [55:0] TXT_STOP    = {"STOP", 24'h0};
    localparam logic [55:0] TXT_START   = {"START", 16'h0};
    localparam logic [55:0] TXT_SCALE_F = "SCALE=F";
    localparam logic [55:0] TXT_SCALE_C = "SCALE=C";
    localparam logic [55:0] TXT_PERIOD  = "PERIOD=";

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;

    // Outcome of one byte, handed from the scanner to the settings logic
    typedef struct packed {
        logic    too_long;
        logic    line_end;
        logic    hit_any;
        kw_idx_t hit;
        logic    period_ok;
    } scan_evt_t;

    function automatic logic [2:0] kw_len(input kw_idx_t k);
        logic [2:0] len;
        case (k)
            KW_OFF:   len = 3'd3;
            KW_STOP:  len = 3'd4;
            KW_START: len = 3'd5;
            default:  len = 3'd7;
        endcase
        return len;
    endfunction

    // Character i of keyword k
    function automatic logic [7:0] kw_char(input kw_idx_t k, input logic [2:0] i);
        logic [55:0] txt;
        logic [5:0]  sh;
        case (k)
            KW_OFF:     txt = TXT_OFF;
            KW_STOP:    txt = TXT_STOP;
            KW_START:   txt = TXT_START;
            KW_SCALE_F: txt = TXT_SCALE_F;
            KW_SCALE_C: txt = TXT_SCALE_C;
            default:    txt = TXT_PERIOD;
        endcase
        sh = {3'd6 - i, 3'b000};
        return 8'(txt >> sh);
    endfunction

endpackage

[rtl/scp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_cmd_if / scp_rsp_if
// Valid/ready channels for command bytes and for result words.
// ---------------------------------------------------------------------------
interface scp_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;

    modport source (output valid, output cmd_byte, input ready);
    modport sink   (input valid, input cmd_byte, output ready);
endinterface

interface scp_rsp_if;
    logic        valid;
    logic        ready;
    logic        power_on;
    logic        report_enable;
    logic        celsius_mode;
    logic [15:0] period_seconds;
    logic        command_done;
    logic [1:0]  fault_code;

    modport source (output valid, output power_on, output report_enable,
                    output celsius_mode, output period_seconds,
                    output command_done, output fault_code, input ready);
    modport sink   (input valid, input power_on, input report_enable,
                    input celsius_mode, input period_seconds,
                    input command_done, input fault_code, output ready);
endinterface

[rtl/scp_line_scan.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_line_scan
// Per-byte line scanner: prefix match, digit accumulation, line checks.
// ---------------------------------------------------------------------------
module scp_line_scan #(
    parameter int LINE_LIMIT  = 1024,
    parameter int PERIOD_BITS = 16,
    parameter int LEN_W       = $clog2(LINE_LIMIT)
) (
    input  logic [7:0]             byte_in,
    input  logic [LEN_W-1:0]       len,
    input  logic [5:0]             alive,
    input  logic                   text_ended,
    input  logic                   digits_valid,
    input  logic [PERIOD_BITS-1:0] accum,
    output logic [LEN_W-1:0]       len_next,
    output logic [5:0]             alive_next,
    output logic                   text_ended_next,
    output logic                   digits_valid_next,
    output logic [PERIOD_BITS-1:0] accum_next,
    output scp_pkg::scan_evt_t     evt
);
    import scp_pkg::*;

    localparam int                   PROD_W     = PERIOD_BITS + 4;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    logic [5:0]        alive_final;
    logic [PROD_W-1:0] prod;
    logic              is_digit;

    assign is_digit = (byte_in >= CHAR_0) && (byte_in <= CHAR_9);
    // accum * 10 + digit
    assign prod = (PROD_W'(accum) << 3) + (PROD_W'(accum) << 1)
                + PROD_W'(byte_in - CHAR_0);

    always_comb
    begin
        alive_next        = alive;
        text_ended_next   = text_ended;
        digits_valid_next = digits_valid;
        accum_next        = accum;
        len_next          = len + LEN_W'(1);
        if (!text_ended)
        begin
            if (byte_in == BYTE_NUL)
            begin
                text_ended_next = 1'b1;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (LEN_W'(kw_len(3'(k))) > len)
                        alive_next[k] = 1'b0;
                end
            end
            else
            begin
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if ((len < LEN_W'(kw_len(3'(k))))
                        && (byte_in != kw_char(3'(k), len[2:0])))
                        alive_next[k] = 1'b0;
                end
                if (len >= LEN_W'(DIGIT_START))
                begin
                    if (is_digit)
                    begin
                        if (prod > PROD_W'(PERIOD_MAX))
                            accum_next = PERIOD_MAX;
                        else
                            accum_next = PERIOD_BITS'(prod);
                    end
                    else
                    begin
                        digits_valid_next = 1'b0;
                    end
                end
            end
        end
    end

    // Keywords still alive once the line ends here
    always_comb
    begin
        alive_final = alive;
        if (!text_ended)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (LEN_W'(kw_len(3'(k))) > len)
                    alive_final[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        evt.too_long  = (len >= LEN_W'(LINE_LIMIT - 1));
        evt.line_end  = (byte_in == BYTE_LF);
        evt.hit_any   = |alive_final;
        evt.period_ok = digits_valid && (accum != '0);
        evt.hit       = KW_PERIOD;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (alive_final[k])
                evt.hit = 3'(k);
        end
    end

endmodule

[rtl/sensor_command_line_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_command_line_parser
// Command byte parser holding the settings of a temperature reporter.
// ---------------------------------------------------------------------------
// Takes one command byte per cycle and returns one result word per byte,
// carrying power, report enable, scale, period, a command-done strobe and a
// sticky fault code. Throughput is one byte per clock while results are
// taken; each byte passes the input register and then the result register,
// with all matching, digit accumulation and command decoding done in one
// pass of logic between them. A stalled result word does not block the input
// register from filling. After a fault, or once OFF has completed, bytes
// are still taken and answered but change nothing. Configuration writes
// load the period (0 reads as 1, values above the period maximum saturate)
// and the scale directly; they are to be made only while the block is idle.
// No clearing pass is needed after reset.
module sensor_command_line_parser #(
    parameter int LINE_LIMIT  = 1024,
    parameter int PERIOD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  scp_pkg::cfg_index_t  cfg_index,
    input  scp_pkg::cfg_data_t   cfg_data,
    scp_cmd_if.sink              cmd,
    scp_rsp_if.source            rsp
);
    import scp_pkg::*;

    localparam int                     LEN_W      = $clog2(LINE_LIMIT);
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;

    // Line state
    logic [LEN_W-1:0]       len_reg;
    logic [5:0]             alive_reg;
    logic                   text_ended_reg;
    logic                   digits_valid_reg;
    logic [PERIOD_BITS-1:0] accum_reg;

    // Settings
    logic                   power_reg;
    logic                   report_reg;
    logic                   scale_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    fault_t                 fault_reg;

    // Result register
    logic        out_valid_reg;
    logic        res_power_reg;
    logic        res_report_reg;
    logic        res_scale_reg;
    logic [15:0] res_period_reg;
    logic        res_done_reg;
    fault_t      res_fault_reg;

    // Scanner outputs
    logic [LEN_W-1:0]       len_scan;
    logic [5:0]             alive_scan;
    logic                   text_ended_scan;
    logic                   digits_valid_scan;
    logic [PERIOD_BITS-1:0] accum_scan;
    scan_evt_t              evt;

    // Next values
    logic                   power_next;
    logic                   report_next;
    logic                   scale_next;
    logic [PERIOD_BITS-1:0] period_next;
    fault_t                 fault_next;
    logic                   done_next;
    logic                   absorb;
    logic                   clear_line;
    logic [31:0]            period_wide;
    logic [31:0]            cfg_wide;
    logic [PERIOD_BITS-1:0] cfg_period;

    logic advance;
    logic process;

    // Result slot free or being emptied: the pipe moves on
    assign advance   = !out_valid_reg || rsp.ready;
    assign cmd.ready = !in_valid_reg || advance;
    assign process   = advance && in_valid_reg;

    scp_line_scan #(
        .LINE_LIMIT  (LINE_LIMIT),
        .PERIOD_BITS (PERIOD_BITS),
        .LEN_W       (LEN_W)
    ) u_scan (
        .byte_in           (byte_reg),
        .len               (len_reg),
        .alive             (alive_reg),
        .text_ended        (text_ended_reg),
        .digits_valid      (digits_valid_reg),
        .accum             (accum_reg),
        .len_next          (len_scan),
        .alive_next        (alive_scan),
        .text_ended_next   (text_ended_scan),
        .digits_valid_next (digits_valid_scan),
        .accum_next        (accum_scan),
        .evt               (evt)
    );

    // Command decode: a line feed executes the first keyword still alive
    always_comb
    begin
        power_next  = power_reg;
        report_next = report_reg;
        scale_next  = scale_reg;
        period_next = period_reg;
        fault_next  = fault_reg;
        done_next   = 1'b0;
        absorb      = 1'b0;
        clear_line  = 1'b0;
        if ((fault_reg == FAULT_NONE) && power_reg)
        begin
            if (evt.too_long)
            begin
                fault_next = FAULT_TOO_LONG;
            end
            else if (evt.line_end)
            begin
                if (!evt.hit_any)
                begin
                    fault_next = FAULT_INVALID;
                end
                else
                begin
                    done_next  = 1'b1;
                    clear_line = 1'b1;
                    case (evt.hit)
                        KW_OFF:     power_next  = 1'b0;
                        KW_STOP:    report_next = 1'b0;
                        KW_START:   report_next = 1'b1;
                        KW_SCALE_F: scale_next  = 1'b0;
                        KW_SCALE_C: scale_next  = 1'b1;
                        default:
                        begin
                            if (evt.period_ok)
                            begin
                                period_next = accum_reg;
                            end
                            else
                            begin
                                fault_next = FAULT_PERIOD;
                                done_next  = 1'b0;
                                clear_line = 1'b0;
                            end
                        end
                    endcase
                end
            end
            else
            begin
                absorb = 1'b1;
            end
        end
    end

    // Period register load from the configuration port
    assign cfg_wide = 32'(cfg_data);
    always_comb
    begin
        if (cfg_wide == 32'd0)
            cfg_period = PERIOD_BITS'(1);
        else if (cfg_wide > 32'(PERIOD_MAX))
            cfg_period = PERIOD_MAX;
        else
            cfg_period = PERIOD_BITS'(cfg_wide);
    end

    assign period_wide = 32'(period_next);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            byte_reg <= cmd.cmd_byte;
    end

    // Line state and settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            alive_reg        <= '1;
            text_ended_reg   <= 1'b0;
            digits_valid_reg <= 1'b1;
            accum_reg        <= '0;
            power_reg        <= 1'b1;
            report_reg       <= 1'b1;
            scale_reg        <= 1'b0;
            period_reg       <= PERIOD_BITS'(1);
            fault_reg        <= FAULT_NONE;
        end
        else if (process)
        begin
            power_reg  <= power_next;
            report_reg <= report_next;
            scale_reg  <= scale_next;
            period_reg <= period_next;
            fault_reg  <= fault_next;
            if (clear_line)
            begin
                len_reg          <= '0;
                alive_reg        <= '1;
                text_ended_reg   <= 1'b0;
                digits_valid_reg <= 1'b1;
                accum_reg        <= '0;
            end
            else if (absorb)
            begin
                len_reg          <= len_scan;
                alive_reg        <= alive_scan;
                text_ended_reg   <= text_ended_scan;
                digits_valid_reg <= digits_valid_scan;
                accum_reg        <= accum_scan;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_PERIOD:  period_reg <= cfg_period;
                REG_START_CELSIUS: scale_reg  <= cfg_data[0];
                default:           period_reg <= period_reg;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            res_power_reg  <= power_next;
            res_report_reg <= report_next;
            res_scale_reg  <= scale_next;
            res_period_reg <= period_wide[15:0];
            res_done_reg   <= done_next;
            res_fault_reg  <= fault_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.power_on       = res_power_reg;
    assign rsp.report_enable  = res_report_reg;
    assign rsp.celsius_mode   = res_scale_reg;
    assign rsp.period_seconds = res_period_reg;
    assign rsp.command_done   = res_done_reg;
    assign rsp.fault_code     = res_fault_reg;

    // Faults hold until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_reg != FAULT_NONE) |=> (fault_reg == $past(fault_reg)))
        else $error("fault code changed after a fault");

    // Once off, the block stays off
    a_power_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !power_reg |=> !power_reg)
        else $error("power came back without reset");

    // A completed command never comes with a fault
    a_done_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.command_done) |-> (rsp.fault_code == FAULT_NONE))
        else $error("command done reported with a fault");

    // Line length never passes the limit
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_LIMIT - 1))
        else $error("line length beyond limit");

endmodule
